// File: rtl/arpudp_pkg.sv
// ----------------------------------------------------------------------------
// arpudp_pkg
// Shared types, codes and byte helpers of the ARP responder and UDP header
// generator.
// ----------------------------------------------------------------------------
package arpudp_pkg;

  localparam int unsigned FRAME_BYTES = 42;
  localparam int unsigned CNT_W       = 6;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_BYTES);
  localparam int unsigned CMD_DEPTH   = 2;

  localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ARP_HTYPE_ETH = 16'h0001;
  localparam logic [7:0]  ARP_HLEN      = 8'h06;
  localparam logic [7:0]  ARP_PLEN      = 8'h04;
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [7:0]  IP_TTL        = 8'hFF;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'h11;
  localparam logic [15:0] UDP_HDR_LEN   = 16'd8;
  localparam logic [15:0] IP_HDR_LEN    = 16'd20;
  localparam logic [47:0] MAC_BCAST     = 48'hFFFF_FFFF_FFFF;

  localparam logic [7:0] ARP_OP_REQUEST = 8'h01;
  localparam logic [7:0] ARP_OP_REPLY   = 8'h02;

  typedef enum logic [1:0] {
    REQ_RX_BYTE  = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_UDP_SEND = 2'd2,
    REQ_SET_LINK = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    CFG_LOCAL_MAC   = 3'd0,
    CFG_LOCAL_IP    = 3'd1,
    CFG_REMOTE_IP   = 3'd2,
    CFG_LOCAL_PORT  = 3'd3,
    CFG_REMOTE_PORT = 3'd4,
    CFG_INIT_RMAC   = 3'd5
  } cfg_index_e;

  // Static addressing seen by the frame builder.
  typedef struct packed {
    logic [47:0] local_mac;
    logic [31:0] local_ip;
    logic [31:0] remote_ip;
    logic [15:0] local_port;
    logic [15:0] remote_port;
  } cfg_t;

  // One queued frame to build.
  typedef struct packed {
    logic        is_udp;
    logic        is_reply;
    logic [47:0] dest_mac;
    logic [15:0] ident;
    logic [10:0] plen;
    logic        link;
  } cmd_t;

  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = mac[47:40];
      3'd1:    b = mac[39:32];
      3'd2:    b = mac[31:24];
      3'd3:    b = mac[23:16];
      3'd4:    b = mac[15:8];
      3'd5:    b = mac[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = ip[31:24];
      2'd1:    b = ip[23:16];
      2'd2:    b = ip[15:8];
      2'd3:    b = ip[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/arp_resolver_udp_header_gen_unit.sv
// ----------------------------------------------------------------------------
// arp_resolver_udp_header_gen_unit
// ARP responder and UDP/IPv4 header generator with a decoupled parser front
// and frame builder back.
// ----------------------------------------------------------------------------
// Path: a frame or header run passes through the command queue and then the
// output register; its first byte appears on out_valid_o once the builder
// has loaded it from the queue head into the output register.
// Throughput: one input beat per cycle while the command queue has room;
// the builder drains one byte per cycle while out_ready_i is high; each run
// occupies 42 output beats through the single byte-wide output register.
// Reset: rst_ni resets control and state, link down, both MAC stores zero.
// ----------------------------------------------------------------------------
module arp_resolver_udp_header_gen_unit import arpudp_pkg::*; #(
  parameter int unsigned CmdDepth = CMD_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  input  logic [10:0] payload_len_i,
  input  logic        link_value_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic        frame_kind_o,
  output logic        link_up_o
);

  // The front owns every piece of state that later beats may change, so each
  // queued command carries its own copy of the destination MAC, identifier
  // and link state. Configuration must only be written while idle (the block
  // does not enforce it), so the builder can read the addressing registers directly.
  cmd_t cmd_push_data, cmd_head;
  cfg_t cfg;
  logic cmd_push, cmd_pop, cmd_full, cmd_empty;

  arpudp_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .req_type_i,
    .rx_byte_i,
    .rx_last_i,
    .payload_len_i,
    .link_value_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_push_data),
    .cfg_o      (cfg)
  );

  // The queue lets the front keep taking beats while a run is still being
  // serialised; it only back-pressures once it is full.
  arpudp_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (cmd_push),
    .data_i  (cmd_push_data),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_head)
  );

  // The builder pops a command as it loads the final byte of its run.
  arpudp_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o,
    .out_ready_i,
    .tx_byte_o,
    .tx_last_o,
    .frame_kind_o,
    .link_up_o
  );

endmodule

// File: rtl/arpudp_front.sv
// ----------------------------------------------------------------------------
// arpudp_front
// Accepts request beats, parses received frames, keeps link and addressing
// state and queues frame build commands.
// ----------------------------------------------------------------------------
module arpudp_front import arpudp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  input  logic [10:0] payload_len_i,
  input  logic        link_value_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        cmd_full_i,
  output logic        cmd_push_o,
  output cmd_t        cmd_o,
  output cfg_t        cfg_o
);

  cfg_t        cfg_q, cfg_d;
  logic [5:0]  rx_count_q, rx_count_d;
  logic        dest_match_q, dest_match_d;
  logic [15:0] ether_type_q, ether_type_d;
  logic [15:0] arp_opcode_q, arp_opcode_d;
  logic [47:0] smac_q, smac_d;
  logic        tip_match_q, tip_match_d;
  logic        link_q, link_d;
  logic [47:0] arp_dmac_q, arp_dmac_d;
  logic [47:0] udp_dmac_q, udp_dmac_d;
  logic [15:0] ident_q, ident_d;
  logic [5:0]  ip_off;
  logic        accept;
  req_type_e   req;
  logic        frame_ok;

  assign in_ready_o  = ~cmd_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i & in_ready_o;
  assign req         = req_type_e'(req_type_i);
  assign cfg_o       = cfg_q;
  assign ip_off      = rx_count_q - 6'd38;

  always_comb begin
    cfg_d        = cfg_q;
    rx_count_d   = rx_count_q;
    dest_match_d = dest_match_q;
    ether_type_d = ether_type_q;
    arp_opcode_d = arp_opcode_q;
    smac_d       = smac_q;
    tip_match_d  = tip_match_q;
    link_d       = link_q;
    arp_dmac_d   = arp_dmac_q;
    udp_dmac_d   = udp_dmac_q;
    ident_d      = ident_q;
    cmd_push_o   = 1'b0;
    cmd_o        = '{is_udp: 1'b0, is_reply: 1'b0, dest_mac: arp_dmac_q,
                     ident: ident_q, plen: payload_len_i, link: link_q};
    frame_ok     = 1'b0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LOCAL_MAC:   cfg_d.local_mac   = cfg_data_i;
        CFG_LOCAL_IP:    cfg_d.local_ip    = cfg_data_i[31:0];
        CFG_REMOTE_IP:   cfg_d.remote_ip   = cfg_data_i[31:0];
        CFG_LOCAL_PORT:  cfg_d.local_port  = cfg_data_i[15:0];
        CFG_REMOTE_PORT: cfg_d.remote_port = cfg_data_i[15:0];
        CFG_INIT_RMAC: begin
          arp_dmac_d = cfg_data_i;
          udp_dmac_d = cfg_data_i;
        end
        default: ;
      endcase
    end

    if (accept) begin
      case (req)
        REQ_RX_BYTE: begin
          if (rx_count_q < FULL_CNT) begin
            if (rx_count_q < 6'd6) begin
              if (rx_byte_i != mac_byte(cfg_q.local_mac, rx_count_q[2:0])) begin
                dest_match_d = 1'b0;
              end
            end else if (rx_count_q == 6'd12 || rx_count_q == 6'd13) begin
              ether_type_d = {ether_type_q[7:0], rx_byte_i};
            end else if (rx_count_q == 6'd20 || rx_count_q == 6'd21) begin
              arp_opcode_d = {arp_opcode_q[7:0], rx_byte_i};
            end else if (rx_count_q >= 6'd22 && rx_count_q < 6'd28) begin
              smac_d = {smac_q[39:0], rx_byte_i};
            end else if (rx_count_q >= 6'd38) begin
              if (rx_byte_i != ip_byte(cfg_q.local_ip, ip_off[1:0])) begin
                tip_match_d = 1'b0;
              end
            end
            rx_count_d = rx_count_q + 6'd1;
          end
          if (rx_last_i) begin
            frame_ok = (rx_count_d == FULL_CNT) && dest_match_d &&
                       (ether_type_d == ETH_TYPE_ARP) && (arp_opcode_d[15:8] == 8'h00);
            if (frame_ok && arp_opcode_d[7:0] == ARP_OP_REQUEST) begin
              // Answer a request with a reply to the stored partner.
              cmd_push_o     = 1'b1;
              cmd_o.is_reply = 1'b1;
            end else if (frame_ok && arp_opcode_d[7:0] == ARP_OP_REPLY && tip_match_d) begin
              arp_dmac_d = smac_d;
              udp_dmac_d = smac_d;
              link_d     = 1'b1;
            end
            rx_count_d   = '0;
            dest_match_d = 1'b1;
            ether_type_d = '0;
            arp_opcode_d = '0;
            smac_d       = '0;
            tip_match_d  = 1'b1;
          end
        end
        REQ_TICK: begin
          if (!link_q) begin
            arp_dmac_d     = MAC_BCAST;
            cmd_push_o     = 1'b1;
            cmd_o.dest_mac = MAC_BCAST;
          end
        end
        REQ_UDP_SEND: begin
          ident_d        = ident_q + 16'd1;
          cmd_push_o     = 1'b1;
          cmd_o.is_udp   = 1'b1;
          cmd_o.dest_mac = udp_dmac_q;
          cmd_o.ident    = ident_d;
        end
        REQ_SET_LINK: link_d = link_value_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= '0;
      rx_count_q   <= '0;
      dest_match_q <= 1'b1;
      ether_type_q <= '0;
      arp_opcode_q <= '0;
      smac_q       <= '0;
      tip_match_q  <= 1'b1;
      link_q       <= 1'b0;
      arp_dmac_q   <= '0;
      udp_dmac_q   <= '0;
      ident_q      <= '0;
    end else begin
      cfg_q        <= cfg_d;
      rx_count_q   <= rx_count_d;
      dest_match_q <= dest_match_d;
      ether_type_q <= ether_type_d;
      arp_opcode_q <= arp_opcode_d;
      smac_q       <= smac_d;
      tip_match_q  <= tip_match_d;
      link_q       <= link_d;
      arp_dmac_q   <= arp_dmac_d;
      udp_dmac_q   <= udp_dmac_d;
      ident_q      <= ident_d;
    end
  end

endmodule

// File: rtl/arpudp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// arpudp_cmd_fifo
// Short command queue between the front and the frame builder.
// ----------------------------------------------------------------------------
module arpudp_cmd_fifo import arpudp_pkg::*; #(
  parameter int unsigned Depth = CMD_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: rtl/arpudp_back.sv
// ----------------------------------------------------------------------------
// arpudp_back
// Frame builder: serialises the head command into 42 output beats through a
// registered output stage.
// ----------------------------------------------------------------------------
module arpudp_back import arpudp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       cmd_empty_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] tx_byte_o,
  output logic       tx_last_o,
  output logic       frame_kind_o,
  output logic       link_up_o
);

  logic [CNT_W-1:0] idx_q, idx_d;
  logic             valid_q, valid_d;
  logic [7:0]       byte_q;
  logic             last_q, kind_q, link_q;
  logic [7:0]       byte_c;
  logic             load, at_last;
  logic [CNT_W-1:0] o6, o22, o28, o32, o38, o26, o30;
  logic [15:0]      ip_len, udp_len;
  logic [47:0]      tgt_mac;

  assign load      = ~cmd_empty_i & (~valid_q | out_ready_i);
  assign at_last   = (idx_q == LAST_IDX);
  assign cmd_pop_o = load & at_last;

  assign o6  = idx_q - 6'd6;
  assign o22 = idx_q - 6'd22;
  assign o26 = idx_q - 6'd26;
  assign o28 = idx_q - 6'd28;
  assign o30 = idx_q - 6'd30;
  assign o32 = idx_q - 6'd32;
  assign o38 = idx_q - 6'd38;

  assign udp_len = {5'b0, cmd_i.plen} + UDP_HDR_LEN;
  assign ip_len  = udp_len + IP_HDR_LEN;
  // A request carries an all-zero target hardware address.
  assign tgt_mac = cmd_i.is_reply ? cmd_i.dest_mac : 48'h0;

  always_comb begin
    byte_c = 8'h00;
    if (idx_q < 6'd6) begin
      byte_c = mac_byte(cmd_i.dest_mac, idx_q[2:0]);
    end else if (idx_q < 6'd12) begin
      byte_c = mac_byte(cfg_i.local_mac, o6[2:0]);
    end else if (!cmd_i.is_udp) begin
      if (idx_q < 6'd22) begin
        case (idx_q)
          6'd12:   byte_c = ETH_TYPE_ARP[15:8];
          6'd13:   byte_c = ETH_TYPE_ARP[7:0];
          6'd14:   byte_c = ARP_HTYPE_ETH[15:8];
          6'd15:   byte_c = ARP_HTYPE_ETH[7:0];
          6'd16:   byte_c = ETH_TYPE_IPV4[15:8];
          6'd17:   byte_c = ETH_TYPE_IPV4[7:0];
          6'd18:   byte_c = ARP_HLEN;
          6'd19:   byte_c = ARP_PLEN;
          6'd21:   byte_c = cmd_i.is_reply ? ARP_OP_REPLY : ARP_OP_REQUEST;
          default: byte_c = 8'h00;
        endcase
      end else if (idx_q < 6'd28) begin
        byte_c = mac_byte(cfg_i.local_mac, o22[2:0]);
      end else if (idx_q < 6'd32) begin
        byte_c = ip_byte(cfg_i.local_ip, o28[1:0]);
      end else if (idx_q < 6'd38) begin
        byte_c = mac_byte(tgt_mac, o32[2:0]);
      end else begin
        byte_c = ip_byte(cfg_i.remote_ip, o38[1:0]);
      end
    end else begin
      if (idx_q >= 6'd26 && idx_q < 6'd30) begin
        byte_c = ip_byte(cfg_i.local_ip, o26[1:0]);
      end else if (idx_q >= 6'd30 && idx_q < 6'd34) begin
        byte_c = ip_byte(cfg_i.remote_ip, o30[1:0]);
      end else begin
        case (idx_q)
          6'd12:   byte_c = ETH_TYPE_IPV4[15:8];
          6'd13:   byte_c = ETH_TYPE_IPV4[7:0];
          6'd14:   byte_c = IP_VER_IHL;
          6'd16:   byte_c = ip_len[15:8];
          6'd17:   byte_c = ip_len[7:0];
          6'd18:   byte_c = cmd_i.ident[15:8];
          6'd19:   byte_c = cmd_i.ident[7:0];
          6'd22:   byte_c = IP_TTL;
          6'd23:   byte_c = IP_PROTO_UDP;
          6'd34:   byte_c = cfg_i.local_port[15:8];
          6'd35:   byte_c = cfg_i.local_port[7:0];
          6'd36:   byte_c = cfg_i.remote_port[15:8];
          6'd37:   byte_c = cfg_i.remote_port[7:0];
          6'd38:   byte_c = udp_len[15:8];
          6'd39:   byte_c = udp_len[7:0];
          default: byte_c = 8'h00;
        endcase
      end
    end
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = at_last ? '0 : idx_q + 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_c;
      last_q <= at_last;
      kind_q <= cmd_i.is_udp;
      link_q <= cmd_i.link;
    end
  end

  assign out_valid_o  = valid_q;
  assign tx_byte_o    = byte_q;
  assign tx_last_o    = last_q;
  assign frame_kind_o = kind_q;
  assign link_up_o    = link_q;

endmodule
